@@ rtl/core/qbez_pkg.sv @@
`timescale 1ns / 1ps

package qbez_pkg;

    localparam int T_FRAC_BITS = 16;
    localparam int COORD_BITS  = 16;
    localparam int T_W         = T_FRAC_BITS + 1;
    localparam int MUL_W       = T_W + 1;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int PT_W        = 48;
    localparam int TOL_W       = 15;
    localparam int TGT_W       = 16;
    localparam int SHR_W       = PROD_W - T_FRAC_BITS;

    localparam logic [T_W-1:0]    T_ONE  = T_W'(1) << T_FRAC_BITS;
    localparam logic [PROD_W-1:0] P_HALF = PROD_W'(1) << (T_FRAC_BITS - 1);

    typedef enum logic [1:0] {
        REG_POINT_ZERO = 2'd0,
        REG_POINT_ONE  = 2'd1,
        REG_POINT_TWO  = 2'd2,
        REG_TOLERANCE  = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_MID    = 4'd2,
        OP_MUL_UU = 4'd3,
        OP_W0     = 4'd4,
        OP_W2     = 4'd5,
        OP_M0     = 4'd6,
        OP_M1     = 4'd7,
        OP_M2     = 4'd8,
        OP_ACC    = 4'd9,
        OP_CHK    = 4'd10,
        OP_EMIT   = 4'd11
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
    } t_dp_sts;

endpackage

@@ rtl/core/qbez_ctrl.sv @@
`timescale 1ns / 1ps

module qbez_ctrl #(
    parameter int MAX_ITER = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_command,
    input  qbez_pkg::t_dp_sts i_sts,
    output logic              o_busy,
    output qbez_pkg::t_dp_cmd o_cmd
);
    import qbez_pkg::*;

    localparam int ITER_W = $clog2(MAX_ITER);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_MID    = 11'b000_0000_0010,
        S_MUL_UU = 11'b000_0000_0100,
        S_W0     = 11'b000_0000_1000,
        S_W2     = 11'b000_0001_0000,
        S_M0     = 11'b000_0010_0000,
        S_M1     = 11'b000_0100_0000,
        S_M2     = 11'b000_1000_0000,
        S_ACC    = 11'b001_0000_0000,
        S_CHK    = 11'b010_0000_0000,
        S_EMIT   = 11'b100_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        MODE_EVAL  = 2'd0,
        MODE_ITER  = 2'd1,
        MODE_FINAL = 2'd2
    } t_mode;

    t_state            r_state, n_state;
    t_mode             r_mode, n_mode;
    logic [1:0]        r_axis, n_axis;
    logic [ITER_W-1:0] r_iter, n_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_EVAL;
            r_axis  <= 2'd0;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_axis  <= n_axis;
            r_iter  <= n_iter;
        end
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_axis  = r_axis;
        n_iter  = r_iter;
        o_cmd.op   = OP_NONE;
        o_cmd.axis = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_iter   = '0;
                    if (i_command) begin
                        n_mode  = MODE_ITER;
                        n_state = S_MID;
                    end else begin
                        n_mode  = MODE_EVAL;
                        n_state = S_MUL_UU;
                    end
                end
            end
            S_MID: begin
                o_cmd.op = OP_MID;
                n_state  = S_MUL_UU;
            end
            S_MUL_UU: begin
                o_cmd.op = OP_MUL_UU;
                n_state  = S_W0;
            end
            S_W0: begin
                o_cmd.op = OP_W0;
                n_state  = S_W2;
            end
            S_W2: begin
                o_cmd.op = OP_W2;
                n_axis   = (r_mode == MODE_ITER) ? 2'd2 : 2'd0;
                n_state  = S_M0;
            end
            S_M0: begin
                o_cmd.op = OP_M0;
                n_state  = S_M1;
            end
            S_M1: begin
                o_cmd.op = OP_M1;
                n_state  = S_M2;
            end
            S_M2: begin
                o_cmd.op = OP_M2;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                if (r_mode == MODE_ITER) begin
                    n_state = S_CHK;
                end else if (r_axis == 2'd2 || (r_mode == MODE_FINAL && r_axis == 2'd1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_M0;
                end
            end
            S_CHK: begin
                o_cmd.op = OP_CHK;
                if (i_sts.hit || r_iter == ITER_W'(MAX_ITER - 1)) begin
                    n_mode  = MODE_FINAL;
                    n_axis  = 2'd0;
                    n_state = S_M0;
                end else begin
                    n_iter  = r_iter + ITER_W'(1);
                    n_state = S_MID;
                end
            end
            S_EMIT: begin
                o_cmd.op = OP_EMIT;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ rtl/core/qbez_dp.sv @@
`timescale 1ns / 1ps

module qbez_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [1:0]                             i_cfg_idx,
    input  logic [qbez_pkg::PT_W-1:0]              i_cfg_data,
    input  logic [qbez_pkg::T_W-1:0]               i_t_value,
    input  logic signed [qbez_pkg::TGT_W-1:0]      i_target_z,
    input  qbez_pkg::t_dp_cmd                      i_cmd,
    output qbez_pkg::t_dp_sts                      o_sts,
    output logic                                   o_valid,
    output logic signed [qbez_pkg::COORD_BITS-1:0] o_point_x,
    output logic signed [qbez_pkg::COORD_BITS-1:0] o_point_y,
    output logic signed [qbez_pkg::COORD_BITS-1:0] o_point_z,
    output logic [qbez_pkg::T_W-1:0]               o_t_result,
    output logic                                   o_found
);
    import qbez_pkg::*;

    localparam logic signed [SHR_W-1:0] C_MAX = SHR_W'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [SHR_W-1:0] C_MIN = -C_MAX - SHR_W'(1);

    function automatic logic signed [COORD_BITS-1:0] coord_sel(
        input logic [PT_W-1:0] p,
        input logic [1:0]      axis
    );
        logic signed [COORD_BITS-1:0] c;
        unique case (axis)
            2'd0:    c = p[0*COORD_BITS +: COORD_BITS];
            2'd1:    c = p[1*COORD_BITS +: COORD_BITS];
            2'd2:    c = p[2*COORD_BITS +: COORD_BITS];
            default: c = '0;
        endcase
        return c;
    endfunction

    logic [PT_W-1:0]                r_p0, r_p1, r_p2;
    logic [TOL_W-1:0]               r_tol;
    logic [T_W-1:0]                 r_t, r_lo, r_hi;
    logic signed [TGT_W-1:0]        r_target;
    logic [T_W-1:0]                 r_w0, r_w1, r_w2;
    logic signed [PROD_W-1:0]       r_prod, r_acc;
    logic signed [COORD_BITS-1:0]   r_coord [3];
    logic                           r_found;
    logic                           r_valid;

    logic [T_W-1:0]                 u_val;
    logic signed [MUL_W-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]              w_round;
    logic [T_W-1:0]                 w_new;
    logic signed [PROD_W-1:0]       acc_sum, acc_rnd;
    logic signed [SHR_W-1:0]        acc_shr;
    logic signed [COORD_BITS-1:0]   coord_sat;
    logic signed [TGT_W:0]          diff;
    logic signed [TGT_W:0]          eps;
    logic                           hit;
    logic [T_W:0]                   mid_sum;
    logic [T_W-1:0]                 t_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0  <= '0;
            r_p1  <= '0;
            r_p2  <= '0;
            r_tol <= TOL_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_POINT_ZERO: r_p0  <= i_cfg_data;
                REG_POINT_ONE:  r_p1  <= i_cfg_data;
                REG_POINT_TWO:  r_p2  <= i_cfg_data;
                REG_TOLERANCE:  r_tol <= i_cfg_data[TOL_W-1:0];
                default:        r_tol <= r_tol;
            endcase
        end
    end

    assign u_val = T_ONE - r_t;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_MUL_UU: begin
                mul_a = $signed({1'b0, u_val});
                mul_b = $signed({1'b0, u_val});
            end
            OP_W0: begin
                mul_a = $signed({1'b0, r_t});
                mul_b = $signed({1'b0, r_t});
            end
            OP_M0: begin
                mul_a = $signed({1'b0, r_w0});
                mul_b = MUL_W'(coord_sel(r_p0, i_cmd.axis));
            end
            OP_M1: begin
                mul_a = $signed({1'b0, r_w1});
                mul_b = MUL_W'(coord_sel(r_p1, i_cmd.axis));
            end
            OP_M2: begin
                mul_a = $signed({1'b0, r_w2});
                mul_b = MUL_W'(coord_sel(r_p2, i_cmd.axis));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign w_round = r_prod + P_HALF;
    assign w_new   = w_round[2*T_FRAC_BITS:T_FRAC_BITS];

    assign acc_sum = r_acc + r_prod;
    assign acc_rnd = acc_sum + $signed(P_HALF);
    assign acc_shr = acc_rnd[PROD_W-1:T_FRAC_BITS];

    always_comb begin
        if (acc_shr > C_MAX) begin
            coord_sat = C_MAX[COORD_BITS-1:0];
        end else if (acc_shr < C_MIN) begin
            coord_sat = C_MIN[COORD_BITS-1:0];
        end else begin
            coord_sat = acc_shr[COORD_BITS-1:0];
        end
    end

    assign diff = (TGT_W+1)'(r_coord[2]) - (TGT_W+1)'(r_target);
    assign eps  = $signed({2'b00, r_tol});
    assign hit  = (diff == '0) || ((diff < eps) && (diff > -eps));
    assign o_sts.hit = hit;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign t_sat   = (i_t_value > T_ONE) ? T_ONE : i_t_value;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_t      <= t_sat;
                r_target <= i_target_z;
                r_lo     <= '0;
                r_hi     <= T_ONE;
                r_found  <= 1'b1;
            end
            OP_MID: begin
                r_t <= mid_sum[T_W:1];
            end
            OP_W0: begin
                r_w0 <= w_new;
            end
            OP_W2: begin
                r_w2 <= w_new;
                r_w1 <= T_ONE - r_w0 - w_new;
            end
            OP_M1: begin
                r_acc <= r_prod;
            end
            OP_M2: begin
                r_acc <= acc_sum;
            end
            OP_ACC: begin
                r_coord[i_cmd.axis] <= coord_sat;
            end
            OP_CHK: begin
                r_found <= hit;
                if (!hit) begin
                    if (diff < 0) begin
                        r_lo <= r_t;
                    end else begin
                        r_hi <= r_t;
                    end
                end
            end
            default: begin
                r_found <= r_found;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == OP_EMIT);
        end
    end

    assign o_valid    = r_valid;
    assign o_point_x  = r_coord[0];
    assign o_point_y  = r_coord[1];
    assign o_point_z  = r_coord[2];
    assign o_t_result = r_t;
    assign o_found    = r_found;

endmodule

@@ rtl/core/quadratic_bezier_eval_and_z_search.sv @@
`timescale 1ns / 1ps

// Quadratic Bezier unit with three control points held in configuration registers.
// Raise start for one cycle while busy is low to hand over an item: command 0 evaluates
// the curve at t_value, command 1 bisects t for target_z, each halving taking a midpoint,
// two weight products, three z products, an accumulate and a compare, for at most
// MAX_ITER halvings, and then computes x and y. All products share one 18x18
// signed multiplier. The result shows for exactly one cycle with o_valid high and cannot
// be held off; take it in that cycle. Busy drops in the same cycle, so the next item may
// follow at once. Write configuration only while idle.
module quadratic_bezier_eval_and_z_search #(
    parameter int MAX_ITER = 17
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_cfg_we,
    input  logic [1:0]                             i_cfg_idx,
    input  logic [qbez_pkg::PT_W-1:0]              i_cfg_data,
    input  logic                                   i_command,
    input  logic [qbez_pkg::T_W-1:0]               i_t_value,
    input  logic signed [qbez_pkg::TGT_W-1:0]      i_target_z,
    output logic                                   o_valid,
    output logic signed [qbez_pkg::COORD_BITS-1:0] o_point_x,
    output logic signed [qbez_pkg::COORD_BITS-1:0] o_point_y,
    output logic signed [qbez_pkg::COORD_BITS-1:0] o_point_z,
    output logic [qbez_pkg::T_W-1:0]               o_t_result,
    output logic                                   o_found
);
    import qbez_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    qbez_ctrl #(
        .MAX_ITER(MAX_ITER)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_command(i_command),
        .i_sts    (sts),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    qbez_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_t_value (i_t_value),
        .i_target_z(i_target_z),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_valid   (o_valid),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y),
        .o_point_z (o_point_z),
        .o_t_result(o_t_result),
        .o_found   (o_found)
    );

endmodule
